/* hdl/mpd_pkg.sv */
package mpd_pkg;

   // one input word: a byte of the data section and the end-of-file mark
   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   // one result word
   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] stream_number;
      logic [31:0] timecode;
      logic [7:0]  reserved_byte;
      logic [7:0]  packet_flags;
      logic [15:0] frame_length;
      logic [7:0]  payload_byte;
      logic        last_of_frame;
   } rsp_type;

   // event codes
   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_START  = 3'd1;
   localparam logic [2:0] EV_BYTE   = 3'd2;
   localparam logic [2:0] EV_END    = 3'd3;
   localparam logic [2:0] EV_TRUNC  = 3'd4;
   localparam logic [2:0] EV_BADLEN = 3'd5;

   // parser phases
   typedef enum logic [4:0] {
      PH_OBJECT  = 5'b00001,
      PH_CHUNK   = 5'b00010,
      PH_HEADER  = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_DONE    = 5'b10000
   } phase_type;

   localparam logic [15:0] FRAME_OVERHEAD = 16'd12;
   localparam logic [31:0] ID_DATA = 32'h4441_5441;
   localparam logic [31:0] ID_INDX = 32'h494E_4458;

endpackage

/* hdl/media_packet_deframer_top.sv */
// channel  direction  ports                            payload
// req      in         req_valid, req_ready, req_data   mpd_pkg::req_type (byte, end mark)
// rsp      out        rsp_valid, rsp_ready, rsp_data   mpd_pkg::rsp_type (event, header, byte)
//
// one word per cycle sustained while rsp does not stall; a word is held in the input register
// and its result, computed by the parser, is then loaded into the result register
// the parser state and the result register both move only when the result register is free
// reset is synchronous and active high; it returns the parser to the object header phase
// a stall on rsp holds both registers; req_ready stays high while the input register is free
module media_packet_deframer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mpd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mpd_pkg::rsp_type rsp_data
);

   // input register
   logic             in_valid_ff;
   mpd_pkg::req_type in_data_ff;

   logic             advance;
   logic             step;
   mpd_pkg::rsp_type step_result;

   // a word leaves the input register when the result register can take its result
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // phase tracking, field capture and event decode
   mpd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (step),
      .item    (in_data_ff),
      .result  (step_result)
   );

   // output register parting the two handshakes
   mpd_result_reg u_result (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .load_data (step_result),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a word held in the input register is kept intact while the output stalls
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("input register lost a stalled word");

   // every parsed word shows up as a result
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("parsed word produced no result");

   // an empty input register never blocks the request side
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("req_ready low with empty input register");

   // a last-of-frame flag only comes with a payload byte event
   a_lof_event: assert property (@(posedge clock) disable iff (reset)
      step && step_result.last_of_frame |-> step_result.event_res == mpd_pkg::EV_BYTE)
      else $error("last_of_frame without payload byte event");
`endif

endmodule

/* hdl/mpd_parser.sv */
module mpd_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  mpd_pkg::req_type item,
   output mpd_pkg::rsp_type result
);

   // byte positions within an object
   localparam logic [3:0] IDX_ID_LAST   = 4'd3;
   localparam logic [3:0] IDX_HDR_FIRST = 4'd4;
   localparam logic [3:0] IDX_STREAM    = 4'd5;
   localparam logic [3:0] IDX_COUNT     = 4'd7;
   localparam logic [3:0] IDX_TIMECODE  = 4'd9;
   localparam logic [3:0] IDX_RESERVED  = 4'd10;
   localparam logic [3:0] IDX_LAST      = 4'd11;

   mpd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  byte_index_ff, byte_index_in;
   logic [31:0] gather_ff, gather_in;
   logic [15:0] payload_left_ff, payload_left_in;
   logic [15:0] stream_ff, stream_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] done_ff, done_in;
   logic [31:0] timecode_ff, timecode_in;
   logic [7:0]  reserved_ff, reserved_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] length_ff, length_in;

   logic [2:0]  ev;
   logic [7:0]  pay;
   logic        lof;
   logic [31:0] shifted;
   logic [7:0]  b;
   logic        last;

   assign b       = item.data_byte;
   assign last    = item.stream_end;
   assign shifted = {gather_ff[23:0], b};

   always_comb begin
      phase_in        = phase_ff;
      byte_index_in   = byte_index_ff;
      gather_in       = gather_ff;
      payload_left_in = payload_left_ff;
      stream_in       = stream_ff;
      total_in        = total_ff;
      done_in         = done_ff;
      timecode_in     = timecode_ff;
      reserved_in     = reserved_ff;
      flags_in        = flags_ff;
      length_in       = length_ff;
      ev              = mpd_pkg::EV_NONE;
      pay             = 8'd0;
      lof             = 1'b0;
      unique case (phase_ff)
         mpd_pkg::PH_OBJECT: begin
            gather_in = shifted;
            if (byte_index_ff >= IDX_ID_LAST) begin
               if (last) begin
                  ev       = mpd_pkg::EV_END;
                  phase_in = mpd_pkg::PH_DONE;
               end else if (shifted == mpd_pkg::ID_DATA) begin
                  phase_in      = mpd_pkg::PH_CHUNK;
                  byte_index_in = IDX_HDR_FIRST;
               end else if (done_ff >= total_ff || shifted == mpd_pkg::ID_INDX) begin
                  ev       = mpd_pkg::EV_END;
                  phase_in = mpd_pkg::PH_DONE;
               end else if (shifted[15:0] < mpd_pkg::FRAME_OVERHEAD) begin
                  ev       = mpd_pkg::EV_BADLEN;
                  phase_in = mpd_pkg::PH_DONE;
               end else begin
                  length_in     = shifted[15:0] - mpd_pkg::FRAME_OVERHEAD;
                  phase_in      = mpd_pkg::PH_HEADER;
                  byte_index_in = IDX_HDR_FIRST;
               end
            end else if (last) begin
               ev       = mpd_pkg::EV_END;
               phase_in = mpd_pkg::PH_DONE;
            end else begin
               byte_index_in = byte_index_ff + 4'd1;
            end
         end
         mpd_pkg::PH_CHUNK: begin
            gather_in = shifted;
            if (byte_index_ff == IDX_COUNT) begin
               total_in = shifted;
            end
            if (last) begin
               ev       = mpd_pkg::EV_END;
               phase_in = mpd_pkg::PH_DONE;
            end else if (byte_index_ff >= IDX_LAST) begin
               done_in       = 32'd0;
               phase_in      = mpd_pkg::PH_OBJECT;
               byte_index_in = 4'd0;
            end else begin
               byte_index_in = byte_index_ff + 4'd1;
            end
         end
         mpd_pkg::PH_HEADER: begin
            gather_in = shifted;
            if (byte_index_ff == IDX_STREAM) begin
               stream_in = shifted[15:0];
            end else if (byte_index_ff == IDX_TIMECODE) begin
               timecode_in = shifted;
            end else if (byte_index_ff == IDX_RESERVED) begin
               reserved_in = b;
            end
            if (byte_index_ff >= IDX_LAST) begin
               flags_in = b;
               if (length_ff == 16'd0) begin
                  ev            = mpd_pkg::EV_START;
                  done_in       = done_ff + 32'd1;
                  phase_in      = last ? mpd_pkg::PH_DONE : mpd_pkg::PH_OBJECT;
                  byte_index_in = 4'd0;
               end else if (last) begin
                  ev       = mpd_pkg::EV_TRUNC;
                  phase_in = mpd_pkg::PH_DONE;
               end else begin
                  ev              = mpd_pkg::EV_START;
                  payload_left_in = length_ff;
                  phase_in        = mpd_pkg::PH_PAYLOAD;
                  byte_index_in   = 4'd0;
               end
            end else if (last) begin
               ev       = mpd_pkg::EV_END;
               phase_in = mpd_pkg::PH_DONE;
            end else begin
               byte_index_in = byte_index_ff + 4'd1;
            end
         end
         mpd_pkg::PH_PAYLOAD: begin
            ev  = mpd_pkg::EV_BYTE;
            pay = b;
            if (payload_left_ff != 16'd0) begin
               payload_left_in = payload_left_ff - 16'd1;
            end
            if (payload_left_in == 16'd0) begin
               lof           = 1'b1;
               done_in       = done_ff + 32'd1;
               phase_in      = last ? mpd_pkg::PH_DONE : mpd_pkg::PH_OBJECT;
               byte_index_in = 4'd0;
            end else if (last) begin
               ev       = mpd_pkg::EV_TRUNC;
               pay      = 8'd0;
               phase_in = mpd_pkg::PH_DONE;
            end
         end
         mpd_pkg::PH_DONE: begin
            phase_in = mpd_pkg::PH_DONE;
         end
         default: begin
            phase_in = mpd_pkg::PH_DONE;
         end
      endcase
   end

   // header fields show the values after this word's update
   always_comb begin
      result.event_res     = ev;
      result.stream_number = stream_in;
      result.timecode      = timecode_in;
      result.reserved_byte = reserved_in;
      result.packet_flags  = flags_in;
      result.frame_length  = length_in;
      result.payload_byte  = pay;
      result.last_of_frame = lof;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= mpd_pkg::PH_OBJECT;
         byte_index_ff   <= 4'd0;
         gather_ff       <= 32'd0;
         payload_left_ff <= 16'd0;
         stream_ff       <= 16'd0;
         total_ff        <= 32'd0;
         done_ff         <= 32'd0;
         timecode_ff     <= 32'd0;
         reserved_ff     <= 8'd0;
         flags_ff        <= 8'd0;
         length_ff       <= 16'd0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         byte_index_ff   <= byte_index_in;
         gather_ff       <= gather_in;
         payload_left_ff <= payload_left_in;
         stream_ff       <= stream_in;
         total_ff        <= total_in;
         done_ff         <= done_in;
         timecode_ff     <= timecode_in;
         reserved_ff     <= reserved_in;
         flags_ff        <= flags_in;
         length_ff       <= length_in;
      end
   end

endmodule

/* hdl/mpd_result_reg.sv */
module mpd_result_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  mpd_pkg::rsp_type load_data,
   output logic             advance,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mpd_pkg::rsp_type rsp_data
);

   logic             valid_ff;
   mpd_pkg::rsp_type data_ff;

   // the register may take a new word when empty or being drained
   assign advance   = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load) begin
         data_ff <= load_data;
      end
   end

endmodule

/* dv/testbench.sv */
// expected result words of the deframer and the parser state that predicts them
class deframe_scoreboard;
   mpd_pkg::rsp_type   due_words[$];
   int unsigned        failures;

   mpd_pkg::phase_type phase;
   logic [15:0] byte_pos;
   logic [31:0] shift_word;
   logic [15:0] bytes_left;
   logic [15:0] stream_hold;
   logic [31:0] timecode_hold;
   logic [7:0]  reserved_hold;
   logic [7:0]  flags_hold;
   logic [15:0] length_hold;
   logic [31:0] packet_total;
   logic [31:0] packets_read;

   function new();
      phase         = mpd_pkg::PH_OBJECT;
      byte_pos      = '0;
      shift_word    = '0;
      bytes_left    = '0;
      stream_hold   = '0;
      timecode_hold = '0;
      reserved_hold = '0;
      flags_hold    = '0;
      length_hold   = '0;
      packet_total  = '0;
      packets_read  = '0;
      failures      = 0;
   endfunction

   // one accepted input word gives exactly one result word
   function void note_byte(mpd_pkg::req_type w);
      mpd_pkg::rsp_type r;
      logic [31:0]      id;
      r = '0;
      r.event_res = mpd_pkg::EV_NONE;
      case (phase)
         mpd_pkg::PH_PAYLOAD: begin
            r.event_res = mpd_pkg::EV_BYTE;
            r.payload_byte = w.data_byte;
            if (bytes_left != 0) bytes_left--;
            if (bytes_left == 0) begin
               r.last_of_frame = 1'b1;
               packets_read++;
               phase = mpd_pkg::PH_OBJECT;
               byte_pos = '0;
               if (w.stream_end) phase = mpd_pkg::PH_DONE;
            end else if (w.stream_end) begin
               r.event_res = mpd_pkg::EV_TRUNC;
               r.payload_byte = '0;
               phase = mpd_pkg::PH_DONE;
            end
         end
         mpd_pkg::PH_OBJECT: begin
            shift_word = {shift_word[23:0], w.data_byte};
            if (byte_pos >= 3) begin
               id = shift_word;
               if (w.stream_end) begin
                  r.event_res = mpd_pkg::EV_END;
                  phase = mpd_pkg::PH_DONE;
               end else if (id == mpd_pkg::ID_DATA) begin
                  // a chunk header wins whatever the packet count
                  phase = mpd_pkg::PH_CHUNK;
                  byte_pos = 16'd4;
               end else if (packets_read >= packet_total || id == mpd_pkg::ID_INDX) begin
                  r.event_res = mpd_pkg::EV_END;
                  phase = mpd_pkg::PH_DONE;
               end else if (id[15:0] < mpd_pkg::FRAME_OVERHEAD) begin
                  r.event_res = mpd_pkg::EV_BADLEN;
                  phase = mpd_pkg::PH_DONE;
               end else begin
                  length_hold = id[15:0] - mpd_pkg::FRAME_OVERHEAD;
                  phase = mpd_pkg::PH_HEADER;
                  byte_pos = 16'd4;
               end
            end else if (w.stream_end) begin
               r.event_res = mpd_pkg::EV_END;
               phase = mpd_pkg::PH_DONE;
            end else begin
               byte_pos++;
            end
         end
         mpd_pkg::PH_CHUNK: begin
            shift_word = {shift_word[23:0], w.data_byte};
            if (byte_pos == 7) packet_total = shift_word;
            if (w.stream_end) begin
               r.event_res = mpd_pkg::EV_END;
               phase = mpd_pkg::PH_DONE;
            end else if (byte_pos >= 11) begin
               packets_read = '0;
               phase = mpd_pkg::PH_OBJECT;
               byte_pos = '0;
            end else begin
               byte_pos++;
            end
         end
         mpd_pkg::PH_HEADER: begin
            shift_word = {shift_word[23:0], w.data_byte};
            if (byte_pos == 5) stream_hold = shift_word[15:0];
            else if (byte_pos == 9) timecode_hold = shift_word;
            else if (byte_pos == 10) reserved_hold = w.data_byte;
            if (byte_pos >= 11) begin
               flags_hold = w.data_byte;
               if (length_hold == 0) begin
                  r.event_res = mpd_pkg::EV_START;
                  packets_read++;
                  phase = mpd_pkg::PH_OBJECT;
                  byte_pos = '0;
                  if (w.stream_end) phase = mpd_pkg::PH_DONE;
               end else if (w.stream_end) begin
                  r.event_res = mpd_pkg::EV_TRUNC;
                  phase = mpd_pkg::PH_DONE;
               end else begin
                  r.event_res = mpd_pkg::EV_START;
                  bytes_left = length_hold;
                  phase = mpd_pkg::PH_PAYLOAD;
                  byte_pos = '0;
               end
            end else if (w.stream_end) begin
               r.event_res = mpd_pkg::EV_END;
               phase = mpd_pkg::PH_DONE;
            end else begin
               byte_pos++;
            end
         end
         default: begin
            // finished: input ignored until reset
         end
      endcase
      r.stream_number = stream_hold;
      r.timecode      = timecode_hold;
      r.reserved_byte = reserved_hold;
      r.packet_flags  = flags_hold;
      r.frame_length  = length_hold;
      due_words.push_back(r);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         failures++;
         if (failures <= 10)
            $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
   endfunction

   function void check_word(mpd_pkg::rsp_type got);
      mpd_pkg::rsp_type want;
      if (due_words.size() == 0) begin
         failures++;
         if (failures <= 10) $display("result word with nothing outstanding: %p", got);
      end else begin
         want = due_words.pop_front();
         compare_field("event_res", want.event_res, got.event_res);
         compare_field("stream_number", want.stream_number, got.stream_number);
         compare_field("timecode", want.timecode, got.timecode);
         compare_field("reserved_byte", want.reserved_byte, got.reserved_byte);
         compare_field("packet_flags", want.packet_flags, got.packet_flags);
         compare_field("frame_length", want.frame_length, got.frame_length);
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("last_of_frame", want.last_of_frame, got.last_of_frame);
      end
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // random part stops once the stream holds this many words; the closing
   // objects and the ignored tail come on top
   localparam int STREAM_TARGET = 1760;
   localparam int IDLE_PERCENT  = 38;
   // one window of cycles in which neither side idles
   localparam int CALM_FROM     = 1300;
   localparam int CALM_TO       = 2000;
   // receiver hold-off while the sender keeps offering
   localparam int HOLD_AT       = 700;
   localparam int HOLD_CYCLES   = 400;
   // sender waits here until every outstanding result has come back
   localparam int DRAIN_AT      = 900;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int TAIL_CYCLES   = 10;
   localparam int CYCLE_LIMIT   = 60_000;

   // ways the stream is brought to its end; only one per run, since the
   // block stays finished until reset and reset is applied only once
   typedef enum int {
      CLOSE_INDX,
      CLOSE_COUNT,
      CLOSE_EOF_OBJECT,
      CLOSE_EOF_CHUNK,
      CLOSE_CUT_FLAGS,
      CLOSE_CUT_PAYLOAD,
      CLOSE_CLEAN_PAYLOAD,
      CLOSE_CLEAN_EMPTY,
      CLOSE_BAD_LENGTH
   } closing_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   mpd_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   mpd_pkg::rsp_type rsp_data;

   int      cycles = 0;
   logic    calm;

   deframe_scoreboard sb = new();
   mpd_pkg::req_type  req_words[$];

   media_packet_deframer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // cycle count, updated after the edge so every process sees the same value
   always @(posedge clock) cycles <= cycles + 1;
   assign calm = (cycles >= CALM_FROM) && (cycles < CALM_TO);

   // ---------------------------------------------------------------
   // stream building
   // ---------------------------------------------------------------

   function automatic void put_byte(logic [7:0] b, logic last);
      mpd_pkg::req_type w;
      w.data_byte  = b;
      w.stream_end = last;
      req_words.push_back(w);
   endfunction

   // chunk header: "DATA", packet count, next-header offset (ignored)
   // end_at marks the byte carrying the end-of-file flag, -1 for none
   function automatic void put_chunk(logic [31:0] count, int end_at);
      logic [95:0] hdr;
      hdr = {mpd_pkg::ID_DATA, count, 32'($urandom)};
      for (int k = 0; k < 12; k++) put_byte(hdr[95 - 8*k -: 8], k == end_at);
   endfunction

   // packet object: version, length, then stream number, timecode, reserved
   // and flags taken from fields, then length-12 random payload bytes
   function automatic void put_packet(logic [15:0] len, logic [63:0] fields, int end_at);
      logic [15:0] version;
      logic [95:0] hdr;
      int          body;
      version = 16'($urandom);
      // the id must not turn into one of the two markers by accident
      if ({version, len} == mpd_pkg::ID_DATA || {version, len} == mpd_pkg::ID_INDX)
         version[8] = ~version[8];
      hdr  = {version, len, fields};
      body = (len > mpd_pkg::FRAME_OVERHEAD) ? int'(len - mpd_pkg::FRAME_OVERHEAD) : 0;
      for (int k = 0; k < 12; k++) put_byte(hdr[95 - 8*k -: 8], k == end_at);
      for (int k = 0; k < body; k++) put_byte(8'($urandom), 12 + k == end_at);
   endfunction

   // ---------------------------------------------------------------
   // monitor: note accepted input words, then check accepted results
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_data);
         if (rsp_valid && rsp_ready) sb.check_word(rsp_data);
      end
   end

   // ---------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------

   task automatic drive_words();
      int next_word;
      bit sent_all;
      bit drained;
      next_word = 0;
      sent_all  = 1'b0;
      drained   = 1'b0;
      while (!sent_all) begin
         @(posedge clock);
         // a word still waiting for ready keeps valid and payload as they are
         if (!(req_valid && !req_ready)) begin
            if (next_word == req_words.size()) begin
               req_valid <= 1'b0;
               sent_all = 1'b1;
            end else if (next_word == DRAIN_AT && !drained) begin
               // pause with nothing offered until the block has emptied
               req_valid <= 1'b0;
               drained = 1'b1;
               @(posedge clock);
               while (sb.due_words.size() != 0) @(posedge clock);
            end else if (calm || $urandom_range(0, 99) >= IDLE_PERCENT) begin
               req_valid <= 1'b1;
               req_data  <= req_words[next_word];
               next_word++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------
   // receiver: random stalls plus one long hold-off so the block fills up
   // and drops req_ready
   // ---------------------------------------------------------------

   initial begin
      int stall_left;
      bit held;
      stall_left = 0;
      held       = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!held && cycles >= HOLD_AT) begin
            held = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // watchdog
   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------

   initial begin
      int          n;
      int          pick;
      int          spins;
      logic [31:0] count;
      logic [31:0] marker;
      logic [15:0] len;
      closing_type closing;

      // directed opening
      // a chunk with a zero packet count still lets the next chunk open
      put_chunk(32'd0, -1);
      put_chunk('1, -1);
      // frame with no payload, header fields all ones
      put_packet(mpd_pkg::FRAME_OVERHEAD, '1, -1);
      // one payload byte, header fields all zeros
      put_packet(mpd_pkg::FRAME_OVERHEAD + 16'd1, '0, -1);

      // random well-formed chunks; the count either matches the packets that
      // follow, or is far larger; a chunk cut short by the target is simply
      // followed by the next chunk header
      while (req_words.size() < STREAM_TARGET) begin
         n = $urandom_range(1, 10);
         count = ($urandom_range(0, 2) == 0) ? {1'b1, 31'($urandom)} : 32'(n);
         put_chunk(count, -1);
         for (int p = 0; p < n && req_words.size() < STREAM_TARGET; p++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) len = mpd_pkg::FRAME_OVERHEAD;
            else if (pick < 75) len = 16'($urandom_range(13, 44));
            else len = 16'($urandom_range(45, 160));
            put_packet(len, {32'($urandom), 32'($urandom)}, -1);
         end
      end

      // the closing case, picked at random
      closing = closing_type'($urandom_range(0, 8));
      put_chunk((closing == CLOSE_COUNT) ? 32'd1 : 32'hFFFF_FFFF,
                (closing == CLOSE_EOF_CHUNK) ? int'($urandom_range(0, 11)) : -1);
      case (closing)
         CLOSE_INDX: begin
            marker = mpd_pkg::ID_INDX;
            for (int k = 0; k < 4; k++) put_byte(marker[31 - 8*k -: 8], 1'b0);
         end
         CLOSE_COUNT: begin
            // one packet uses the count up, the next object id ends the stream
            put_packet(16'($urandom_range(12, 30)), {32'($urandom), 32'($urandom)}, -1);
            put_packet(16'($urandom_range(12, 30)), {32'($urandom), 32'($urandom)}, -1);
         end
         CLOSE_EOF_OBJECT: begin
            // file ends before the packet header is complete
            put_packet(16'($urandom_range(12, 30)), {32'($urandom), 32'($urandom)},
                       int'($urandom_range(0, 10)));
         end
         CLOSE_CUT_FLAGS: begin
            put_packet(16'($urandom_range(13, 30)), {32'($urandom), 32'($urandom)}, 11);
         end
         CLOSE_CUT_PAYLOAD: begin
            len = 16'($urandom_range(14, 40));
            put_packet(len, {32'($urandom), 32'($urandom)},
                       int'($urandom_range(12, int'(len) - 2)));
         end
         CLOSE_CLEAN_PAYLOAD: begin
            len = 16'($urandom_range(13, 40));
            put_packet(len, {32'($urandom), 32'($urandom)}, int'(len) - 1);
         end
         CLOSE_CLEAN_EMPTY: begin
            put_packet(mpd_pkg::FRAME_OVERHEAD, {32'($urandom), 32'($urandom)}, 11);
         end
         CLOSE_BAD_LENGTH: begin
            put_packet(16'($urandom_range(0, 11)), {32'($urandom), 32'($urandom)}, -1);
         end
         default: begin
            // end of file inside the chunk header, already marked above
         end
      endcase
      // a few words after the end, all of which the block must ignore
      repeat (6) put_byte(8'($urandom), 1'($urandom_range(0, 1)));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      drive_words();

      // let the outstanding results drain, then a short quiet tail
      spins = 0;
      while (sb.due_words.size() != 0 && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.failures += sb.due_words.size();

      if (sb.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/mpd_pkg.sv
hdl/mpd_parser.sv
hdl/mpd_result_reg.sv
hdl/media_packet_deframer_top.sv
dv/testbench.sv
